// ----- src/pagp_pkg.sv -----
// ----------------------------------------------------------------------------
// pagp_pkg: shared types and constants; the package holds no functions
// ----------------------------------------------------------------------------
package pagp_pkg;

   localparam int CountWidth = 32;
   localparam int DimWidth   = 16;
   localparam int StatusWidth = 2;

   localparam logic [DimWidth-1:0] MaxWidthReset  = 16'd16384;
   localparam logic [DimWidth-1:0] MaxHeightReset = 16'd16384;

   localparam int CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrMaxWidth  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxHeight = 1'b1;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_LIMIT    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // phases of the cell chain
   localparam int DivBits  = 16;  // max_cols / max_rows quotient bits
   localparam int SqrtBits = 16;  // isqrt result bits
   localparam int CdivBits = 32;  // ceil division quotient bits

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [DimWidth-1:0]   tw;
      logic [DimWidth-1:0]   th;
      logic [DimWidth-1:0]   mtw;
      logic [DimWidth-1:0]   mth;
      logic                  bad;
      // divisions of the texture limits
      logic [DimWidth:0]     rem_c;
      logic [DimWidth-1:0]   q_c;
      logic [DimWidth:0]     rem_r;
      logic [DimWidth-1:0]   q_r;
      // integer square root
      logic [CountWidth-1:0] sx;
      logic [CountWidth-1:0] sr;
      // generic ceiling divider
      logic [CountWidth:0]   drem;
      logic [CountWidth-1:0] dq;
      logic [CountWidth-1:0] dden;
      logic [DimWidth-1:0]   cols;
      logic [DimWidth-1:0]   rows;
      logic                  fixup;
   } token_type;

endpackage

// ----- src/pagp_if.sv -----
// ----------------------------------------------------------------------------
// pagp_req_if / pagp_rsp_if: valid/ready channels
// ----------------------------------------------------------------------------
interface pagp_req_if;
   import pagp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] probe_count;
   logic [DimWidth-1:0]   tile_width;
   logic [DimWidth-1:0]   tile_height;
   modport source (output valid, probe_count, tile_width, tile_height, input ready);
   modport sink   (input valid, probe_count, tile_width, tile_height, output ready);
endinterface

interface pagp_rsp_if;
   import pagp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [StatusWidth-1:0] status;
   logic [DimWidth-1:0]    grid_columns;
   logic [DimWidth-1:0]    grid_rows;
   logic [DimWidth-1:0]    atlas_width;
   logic [DimWidth-1:0]    atlas_height;
   modport source (output valid, status, grid_columns, grid_rows, atlas_width,
                   atlas_height, input ready);
   modport sink   (input valid, status, grid_columns, grid_rows, atlas_width,
                   atlas_height, output ready);
endinterface

// ----- src/probe_atlas_grid_packer.sv -----
// ----------------------------------------------------------------------------
// probe_atlas_grid_packer: atlas grid sizing for probe tiles
//
// channel | dir | words
// req     | in  | probe_count, tile_width, tile_height
// rsp     | out | status, grid_columns, grid_rows, atlas_width, atlas_height
// csr     | in  | max_texture_width (0), max_texture_height (1)
//
// One word per cycle while the result word is not held, through the cell chain
// (limit division, square root, setup, three ceiling divisions, result shaping).
// The whole chain stalls when the result word is held.
// Synchronous active-high reset clears valid bits and the limits to 16384.
// ----------------------------------------------------------------------------
module probe_atlas_grid_packer
   import pagp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pagp_req_if.sink   req,
   pagp_rsp_if.source rsp,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DimWidth-1:0]      csr_write_data
);

   localparam int NCells = DivBits + SqrtBits + 1 + 3 * CdivBits;

   logic [DimWidth-1:0] mtw_ff, mth_ff;
   logic                advance;
   logic      v [NCells+1];
   token_type t [NCells+1];
   logic      fv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mtw_ff <= MaxWidthReset;
         mth_ff <= MaxHeightReset;
      end else if (csr_write_enable) begin
         if (csr_index == CsrMaxWidth)  mtw_ff <= csr_write_data;
         if (csr_index == CsrMaxHeight) mth_ff <= csr_write_data;
      end
   end

   assign advance   = rsp.ready || !fv;
   assign req.ready = advance;

   always_comb begin
      t[0] = '0;
      t[0].count = req.probe_count;
      t[0].tw = req.tile_width;
      t[0].th = req.tile_height;
      t[0].mtw = mtw_ff;
      t[0].mth = mth_ff;
      t[0].bad = (req.probe_count == '0) || (req.tile_width == '0) ||
                 (req.tile_height == '0) || (mtw_ff == '0) || (mth_ff == '0);
      t[0].sx = req.probe_count;
      v[0] = req.valid;
   end

   for (genvar g = 0; g < NCells; g++) begin : g_cell
      localparam int Ph = (g < DivBits) ? 0 :
                          (g < DivBits + SqrtBits) ? 1 :
                          (g == DivBits + SqrtBits) ? 2 :
                          (g < DivBits + SqrtBits + 1 + CdivBits) ? 3 :
                          (g < DivBits + SqrtBits + 1 + 2 * CdivBits) ? 4 : 5;
      localparam int St = (Ph == 0) ? g :
                          (Ph == 1) ? g - DivBits :
                          (Ph == 2) ? 0 :
                          (g - DivBits - SqrtBits - 1) % CdivBits;
      pagp_cell #(.Phase(Ph), .Step(St)) u_cell (
         .clock, .reset, .advance,
         .valid_in(v[g]), .tok_in(t[g]),
         .valid_out(v[g+1]), .tok_out(t[g+1])
      );
   end

   status_type st;
   pagp_final u_final (
      .clock, .reset, .advance,
      .valid_in(v[NCells]), .tok_in(t[NCells]),
      .valid_out(fv), .status(st),
      .cols(rsp.grid_columns), .rows(rsp.grid_rows),
      .aw(rsp.atlas_width), .ah(rsp.atlas_height)
   );

   assign rsp.valid  = fv;
   assign rsp.status = st;

endmodule

// ----- src/pagp_cell.sv -----
// ----------------------------------------------------------------------------
// pagp_cell: one stage of the packing chain
// Each cell runs one step of the phase given by its position and hands the
// token to the next cell.
// ----------------------------------------------------------------------------
module pagp_cell
   import pagp_pkg::*;
#(
   parameter int Phase = 0,   // 0 lim div, 1 sqrt, 2 setup, 3 cdiv, 4/5 fix
   parameter int Step  = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  token_type tok_in,
   output logic      valid_out,
   output token_type tok_out
);

   localparam int DimBit    = (Step < DimWidth) ? DimWidth - 1 - Step : 0;
   localparam int SqrtShift = (Step < SqrtBits) ? CountWidth - 2 - 2 * Step : 0;

   logic      valid_ff;
   token_type tok_ff, tok_in_n;

   always_comb begin
      logic [DimWidth:0]     tc, tr;
      logic [CountWidth-1:0] bitv, t;
      logic [CountWidth:0]   dt;
      tok_in_n = tok_in;
      tc = '0; tr = '0; bitv = '0; t = '0; dt = '0;
      case (Phase)
         0: begin
            tc = {tok_in.rem_c[DimWidth-1:0], tok_in.mtw[DimBit]};
            tr = {tok_in.rem_r[DimWidth-1:0], tok_in.mth[DimBit]};
            if (tc >= {1'b0, tok_in.tw}) begin
               tok_in_n.rem_c = tc - {1'b0, tok_in.tw};
               tok_in_n.q_c[DimBit] = 1'b1;
            end else begin
               tok_in_n.rem_c = tc;
            end
            if (tr >= {1'b0, tok_in.th}) begin
               tok_in_n.rem_r = tr - {1'b0, tok_in.th};
               tok_in_n.q_r[DimBit] = 1'b1;
            end else begin
               tok_in_n.rem_r = tr;
            end
         end
         1: begin
            bitv = CountWidth'(1) << SqrtShift;
            t = tok_in.sr + bitv;
            if (tok_in.sx >= t) begin
               tok_in_n.sx = tok_in.sx - t;
               tok_in_n.sr = (tok_in.sr >> 1) + bitv;
            end else begin
               tok_in_n.sr = tok_in.sr >> 1;
            end
            if (Step == SqrtBits - 1) begin
               if (tok_in_n.sx != '0) tok_in_n.sr = tok_in_n.sr + CountWidth'(1);
            end
         end
         2: begin
            // cols = min(ceil sqrt, max_cols); divide count by cols
            tok_in_n.cols = (tok_in.sr > {16'd0, tok_in.q_c}) ? tok_in.q_c
                                                             : tok_in.sr[DimWidth-1:0];
            tok_in_n.dden = {16'd0, tok_in_n.cols};
            tok_in_n.drem = '0;
            tok_in_n.dq   = '0;
         end
         default: begin
            dt = {tok_in.drem[CountWidth-1:0], tok_in.count[CountWidth-1-Step]};
            if (dt >= {1'b0, tok_in.dden}) begin
               tok_in_n.drem = dt - {1'b0, tok_in.dden};
               tok_in_n.dq[CountWidth-1-Step] = 1'b1;
            end else begin
               tok_in_n.drem = dt;
            end
            if (Step == CdivBits - 1) begin
               t = tok_in_n.dq + ((tok_in_n.drem != '0) ? 32'd1 : 32'd0);
               if (Phase == 3) begin
                  if (t > {16'd0, tok_in.q_r} && tok_in.q_r != '0) begin
                     tok_in_n.fixup = 1'b1;
                     tok_in_n.dden = {16'd0, tok_in.q_r};
                  end else begin
                     tok_in_n.rows = (t > 32'hFFFF) ? 16'hFFFF : t[DimWidth-1:0];
                  end
               end else if (Phase == 4) begin
                  if (tok_in.fixup) begin
                     if (t > {16'd0, tok_in.q_c}) begin
                        tok_in_n.cols = '0;
                     end else begin
                        tok_in_n.cols = t[DimWidth-1:0];
                        tok_in_n.dden = t;
                     end
                  end
               end else if (tok_in.fixup) begin
                  tok_in_n.rows = (t > 32'hFFFF) ? 16'hFFFF : t[DimWidth-1:0];
               end
               tok_in_n.drem = '0;
               tok_in_n.dq   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= valid_in;
      if (advance) tok_ff <= tok_in_n;
   end

   assign valid_out = valid_ff;
   assign tok_out   = tok_ff;

endmodule

// ----- src/pagp_final.sv -----
// ----------------------------------------------------------------------------
// pagp_final: final status checks, atlas size products and result shaping
// ----------------------------------------------------------------------------
module pagp_final
   import pagp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  token_type        tok_in,
   output logic             valid_out,
   output status_type       status,
   output logic [DimWidth-1:0] cols,
   output logic [DimWidth-1:0] rows,
   output logic [DimWidth-1:0] aw,
   output logic [DimWidth-1:0] ah
);

   logic       valid_ff;
   status_type st_ff;
   logic [DimWidth-1:0] c_ff, r_ff, w_ff, h_ff;
   status_type st_in;
   logic [DimWidth-1:0] c_in, r_in;
   logic [2*DimWidth-1:0] w_in, h_in;

   always_comb begin
      c_in = tok_in.cols;
      r_in = tok_in.rows;
      w_in = {{DimWidth{1'b0}}, c_in} * {{DimWidth{1'b0}}, tok_in.tw};
      h_in = {{DimWidth{1'b0}}, r_in} * {{DimWidth{1'b0}}, tok_in.th};
      if (tok_in.bad) st_in = ST_INVALID;
      else if (tok_in.q_c == '0 || tok_in.q_r == '0) st_in = ST_LIMIT;
      else if (tok_in.fixup && c_in == '0) st_in = ST_LIMIT;
      else if (c_in == '0 || c_in > tok_in.q_c || r_in == '0 || r_in > tok_in.q_r)
         st_in = ST_LIMIT;
      else if (w_in > 32'hFFFF || h_in > 32'hFFFF) st_in = ST_OVERFLOW;
      else st_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (advance) valid_ff <= valid_in;
      if (advance) begin
         st_ff <= st_in;
         c_ff  <= (st_in == ST_OK) ? c_in : '0;
         r_ff  <= (st_in == ST_OK) ? r_in : '0;
         w_ff  <= (st_in == ST_OK) ? w_in[DimWidth-1:0] : '0;
         h_ff  <= (st_in == ST_OK) ? h_in[DimWidth-1:0] : '0;
      end
   end

   assign valid_out = valid_ff;
   assign status = st_ff;
   assign cols = c_ff;
   assign rows = r_ff;
   assign aw = w_ff;
   assign ah = h_ff;

endmodule

// ----- src/pagp_checker.sv -----
// ----------------------------------------------------------------------------
// pagp_checker: port-level checks on the packer
// ----------------------------------------------------------------------------
module pagp_checker
   import pagp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [StatusWidth-1:0] rsp_status,
   input logic [DimWidth-1:0] rsp_grid_columns,
   input logic [DimWidth-1:0] rsp_atlas_width
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("rsp word dropped");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("stall without held word");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_grid_columns == '0 &&
      rsp_atlas_width == '0) else $error("error word not zero");
   a_cols: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_grid_columns != '0)
      else $error("ok with zero columns");
endmodule

bind probe_atlas_grid_packer pagp_checker u_pagp_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
   .rsp_grid_columns(rsp.grid_columns), .rsp_atlas_width(rsp.atlas_width)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: probe atlas grid packer testbench
//
// Drives tile counts and sizes under several texture limit settings, with
// random gaps on both channels and one long result hold-off. Every result
// word is checked field by field against an in-order queue of predicted grids.
// ----------------------------------------------------------------------------
module tb_top;
   import pagp_pkg::*;

   localparam int LatencyCycles = 140;
   localparam int CycleLimit    = 1000000;
   localparam int NumPhases     = 8;
   localparam int RandPerPhase  = 192;

   typedef struct packed {
      status_type          st;
      logic [DimWidth-1:0] cols;
      logic [DimWidth-1:0] rows;
      logic [DimWidth-1:0] aw;
      logic [DimWidth-1:0] ah;
   } grid_word_type;

   typedef struct {
      logic [CountWidth-1:0] cnt;
      logic [DimWidth-1:0]   tw;
      logic [DimWidth-1:0]   th;
      bit                    typed;
      grid_word_type         want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [DimWidth-1:0]      csr_write_data;

   pagp_req_if req ();
   pagp_rsp_if rsp ();

   probe_atlas_grid_packer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req.sink),
      .rsp              (rsp.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [DimWidth-1:0] lim_w;
   logic [DimWidth-1:0] lim_h;
   grid_word_type       grid_q[$];
   int                  errors;
   int                  cycles;
   int                  sent;
   bit                  stall_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint unsigned ceil_div(longint unsigned a, longint unsigned b);
      if (b == 0) return 0;
      return a / b + ((a % b) != 0 ? 1 : 0);
   endfunction

   function automatic grid_word_type pack_grid(logic [CountWidth-1:0] cnt,
                                            logic [DimWidth-1:0] tw, logic [DimWidth-1:0] th,
                                            logic [DimWidth-1:0] mw, logic [DimWidth-1:0] mh);
      longint unsigned mc, mr, c, r, w, h, rt, t;
      grid_word_type g;
      g.st = ST_INVALID;
      g.cols = '0;
      g.rows = '0;
      g.aw = '0;
      g.ah = '0;
      if (cnt == 0 || tw == 0 || th == 0 || mw == 0 || mh == 0) return g;
      g.st = ST_LIMIT;
      mc = mw / tw;
      mr = mh / th;
      if (mc == 0 || mr == 0) return g;
      rt = 0;
      for (int b = 16; b >= 0; b--) begin
         t = rt | (64'd1 << b);
         if (t * t <= cnt) rt = t;
      end
      if (rt * rt < cnt) rt++;
      c = (rt > mc) ? mc : rt;
      r = ceil_div(cnt, c);
      if (r > mr) begin
         c = ceil_div(cnt, mr);
         r = ceil_div(cnt, c);
      end
      if (c == 0 || c > mc || r == 0 || r > mr) return g;
      w = c * tw;
      h = r * th;
      if (w > 16'hFFFF || h > 16'hFFFF) begin
         g.st = ST_OVERFLOW;
         return g;
      end
      g.st = ST_OK;
      g.cols = c[15:0];
      g.rows = r[15:0];
      g.aw = w[15:0];
      g.ah = h[15:0];
      return g;
   endfunction

   function automatic grid_word_type err_word(status_type s);
      grid_word_type g;
      g = '0;
      g.st = s;
      return g;
   endfunction

   task automatic write_limit(logic [CsrIndexWidth-1:0] idx, logic [DimWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CsrMaxWidth) lim_w = val;
      else lim_h = val;
   endtask

   task automatic send_word(stim_row_type s);
      int gap;
      req.valid <= 1'b1;
      req.probe_count <= s.cnt;
      req.tile_width <= s.tw;
      req.tile_height <= s.th;
      do @(posedge clock); while (!req.ready);
      grid_q.push_back(s.typed ? s.want : pack_grid(s.cnt, s.tw, s.th, lim_w, lim_h));
      sent++;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: gap = $urandom_range(1, 3);
         4: gap = $urandom_range(10, 40);
         default: gap = 0;
      endcase
      if (sent / 64 % 3 == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (grid_q.size() != 0) @(posedge clock);
      repeat (LatencyCycles) @(posedge clock);
   endtask

   function automatic stim_row_type rand_row();
      stim_row_type s;
      s.typed = 0;
      s.want = '0;
      case ($urandom_range(0, 9))
         0: s.cnt = $urandom();
         1: s.cnt = $urandom() >> $urandom_range(0, 31);
         2: s.cnt = $urandom_range(0, 3);
         default: s.cnt = $urandom_range(1, 5000);
      endcase
      case ($urandom_range(0, 9))
         0: s.tw = DimWidth'($urandom());
         1: s.tw = DimWidth'($urandom_range(0, 1));
         default: s.tw = DimWidth'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
         0: s.th = DimWidth'($urandom());
         1: s.th = DimWidth'($urandom_range(0, 1));
         default: s.th = DimWidth'($urandom_range(1, 64));
      endcase
      return s;
   endfunction

   stim_row_type dir_tab[$];

   initial begin
      stim_row_type s;
      reset = 1'b1;
      req.valid = 1'b0;
      req.probe_count = '0;
      req.tile_width = '0;
      req.tile_height = '0;
      csr_write_enable = 1'b0;
      csr_index = CsrMaxWidth;
      csr_write_data = '0;
      lim_w = MaxWidthReset;
      lim_h = MaxHeightReset;
      errors = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_tab = '{
         '{32'd0, 16'd8, 16'd8, 1'b1, err_word(ST_INVALID)},
         '{32'd5, 16'd0, 16'd8, 1'b1, err_word(ST_INVALID)},
         '{32'd5, 16'd8, 16'd0, 1'b1, err_word(ST_INVALID)},
         '{32'd1, 16'd1, 16'd1, 1'b1, '{ST_OK, 16'd1, 16'd1, 16'd1, 16'd1}},
         '{32'd4, 16'd2, 16'd3, 1'b1, '{ST_OK, 16'd2, 16'd2, 16'd4, 16'd6}},
         '{32'd1, 16'd16385, 16'd1, 1'b1, err_word(ST_LIMIT)},
         '{32'd1, 16'd1, 16'd16385, 1'b1, err_word(ST_LIMIT)},
         '{32'd1, 16'hFFFF, 16'hFFFF, 1'b1, err_word(ST_LIMIT)},
         '{32'hFFFFFFFF, 16'd1, 16'd1, 1'b1, err_word(ST_LIMIT)},
         '{32'd1, 16'd16384, 16'd16384, 1'b0, '0},
         '{32'd268435456, 16'd1, 16'd1, 1'b0, '0},
         '{32'd268435457, 16'd1, 16'd1, 1'b0, '0},
         '{32'd16385, 16'd1, 16'd1, 1'b0, '0},
         '{32'd100, 16'd4096, 16'd1, 1'b0, '0},
         '{32'd5, 16'd8192, 16'd8192, 1'b0, '0},
         '{32'd4, 16'd8192, 16'd8192, 1'b0, '0},
         '{32'd17, 16'd3, 16'd7, 1'b0, '0},
         '{32'h80000000, 16'd1, 16'd1, 1'b0, '0},
         '{32'd65535, 16'd2, 16'd2, 1'b0, '0},
         '{32'd3, 16'd5461, 16'd1, 1'b0, '0}
      };
      foreach (dir_tab[i]) send_word(dir_tab[i]);

      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph > 0) begin
            wait_idle();
            case (ph)
               1: begin write_limit(CsrMaxWidth, 16'hFFFF); write_limit(CsrMaxHeight, 16'hFFFF); end
               2: begin write_limit(CsrMaxWidth, 16'd0); write_limit(CsrMaxHeight, 16'd100); end
               3: begin write_limit(CsrMaxWidth, 16'd100); write_limit(CsrMaxHeight, 16'd0); end
               4: begin write_limit(CsrMaxWidth, 16'd1); write_limit(CsrMaxHeight, 16'd1); end
               5: begin write_limit(CsrMaxWidth, 16'd37); write_limit(CsrMaxHeight, 16'hFFFF); end
               default: begin
                  write_limit(CsrMaxWidth, DimWidth'($urandom()));
                  write_limit(CsrMaxHeight, DimWidth'($urandom()));
               end
            endcase
         end
         for (int n = 0; n < RandPerPhase; n++) begin
            s = rand_row();
            send_word(s);
         end
      end
      wait_idle();
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // result side back-pressure, one long hold-off once 300 request words were sent
   initial begin
      int mode;
      int hold;
      rsp.ready = 1'b0;
      stall_done = 0;
      mode = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!stall_done && sent >= 300) begin
            stall_done = 1;
            rsp.ready <= 1'b0;
            for (hold = 0; hold < 500; hold++) @(posedge clock);
         end
         if (cycles % 300 == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if ($urandom_range(0, 30) == 0) begin
                  rsp.ready <= 1'b0;
                  repeat ($urandom_range(10, 60)) @(posedge clock);
               end
               rsp.ready <= ($urandom_range(0, 1) != 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      grid_word_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (grid_q.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            w = grid_q.pop_front();
            if (rsp.status !== w.st) begin
               $error("status exp %0d got %0d", w.st, rsp.status); errors++;
            end
            if (rsp.grid_columns !== w.cols) begin
               $error("grid_columns exp %0d got %0d", w.cols, rsp.grid_columns); errors++;
            end
            if (rsp.grid_rows !== w.rows) begin
               $error("grid_rows exp %0d got %0d", w.rows, rsp.grid_rows); errors++;
            end
            if (rsp.atlas_width !== w.aw) begin
               $error("atlas_width exp %0d got %0d", w.aw, rsp.atlas_width); errors++;
            end
            if (rsp.atlas_height !== w.ah) begin
               $error("atlas_height exp %0d got %0d", w.ah, rsp.atlas_height); errors++;
            end
         end
      end
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

endmodule
